>>> sv/detune_to_cents_assert.svh
// ----------------------------------------------------------------------------
// detune_to_cents assertion macros
// Clocked property wrappers shared by the detune_to_cents RTL.
// ----------------------------------------------------------------------------
`ifndef DETUNE_TO_CENTS_ASSERT_SVH
`define DETUNE_TO_CENTS_ASSERT_SVH

// same-cycle implication
`define DTC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Field widths, detune type codes and fixed-point constants for detune_to_cents.
// ----------------------------------------------------------------------------
package dtc_pkg;

   localparam int TYPE_W   = 3;
   localparam int COARSE_W = 14;
   localparam int FINE_W   = 14;
   localparam int OUT_W    = 28;

   localparam logic [TYPE_W-1:0] DT_TEN_CENT = 3'd2;
   localparam logic [TYPE_W-1:0] DT_DECIMAL  = 3'd3;
   localparam logic [TYPE_W-1:0] DT_FIFTHS   = 3'd4;

   localparam int OCT_W  = 4;
   localparam int STEP_W = 10;
   localparam int CMAG_W = 10;
   localparam int MAG_W  = 14;

   localparam logic [STEP_W-1:0] STEP_HALF  = 10'd512;
   localparam logic [FINE_W-1:0] FINE_ZERO  = 14'd8192;
   localparam int                FINE_SHIFT = 13;

   // fine exponent scale factors, units of 2^-32 per fine count
   localparam int               K_W       = 23;
   localparam logic [K_W-1:0]   K_FIFTHS  = 23'd6291456;
   localparam logic [K_W-1:0]   K_DECIMAL = 23'd5224941;
   localparam int               E_W       = MAG_W + 22;
   localparam int               EXP_INT_W = 4;

   // just fifth in cents, Q24
   localparam int                 FIFTH_W   = 34;
   localparam logic [FIFTH_W-1:0] FIFTH_Q24 = 34'd11776850672;

   localparam logic [63:0] LN2_Q32 = 64'd2977044472;

   localparam int                POW_W    = 32;
   localparam logic [POW_W-1:0]  Q30_ONE  = 32'h4000_0000;
   localparam int                P_W      = POW_W + 12;

   localparam int CENTS_OCTAVE  = 1200;
   localparam int SCALE_TEN     = 10;
   localparam int SCALE_DEC     = 100;
   localparam int SCALE_DEF     = 50;
   localparam int FINE_MUL_TEN  = 10;
   localparam int FINE_MUL_DEF  = 35;
   localparam int DEC_DIV       = 10;
   localparam int FIFTHS_CENTS  = 1200;
   localparam int FIFTHS_DIV    = 4095;
   localparam int FIFTHS_DIV_SH = 12;

   localparam int POW_TABLE_ENTRIES_DEF = 1024;
   localparam int OUT_FRAC_BITS_DEF     = 8;

endpackage

>>> sv/detune_to_cents.sv
// ----------------------------------------------------------------------------
// detune_to_cents
// Detune setting (type, coarse, fine) to signed cents offset in fixed point.
// ----------------------------------------------------------------------------
// Throughput is one request per clock while rsp_stall is low. There are nine
// register stages to rsp_valid: decode and fine exponent multiply, table
// position multiply, 2^x table read (two read ports), interpolation multiply,
// exponent shift, scaling, reciprocal divide, divide correction, then the
// signed sum and saturation. Each stage holds its request until the next one
// frees up, so bubbles are squeezed out under rsp_stall. The 2^x table is a
// constant ROM built at elaboration; there is no start-up delay after reset.
`include "detune_to_cents_assert.svh"

module detune_to_cents import dtc_pkg::*; #(
   parameter int POW_TABLE_ENTRIES = POW_TABLE_ENTRIES_DEF,
   parameter int OUT_FRAC_BITS     = OUT_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [TYPE_W-1:0]   req_detune_type,
   input  logic [COARSE_W-1:0] req_coarse_word,
   input  logic [FINE_W-1:0]   req_fine_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [OUT_W-1:0]    rsp_cents_offset
);

   localparam int NSTAGE   = 9;
   localparam int ROM_AW   = $clog2(POW_TABLE_ENTRIES + 1);
   localparam int POS_W    = 32 + ROM_AW;
   localparam int SH       = 30 - OUT_FRAC_BITS;
   localparam int C_W      = OUT_FRAC_BITS + 21;
   localparam int FV_W     = OUT_FRAC_BITS + 12;
   localparam int FL_W     = MAG_W + 7 + OUT_FRAC_BITS;
   localparam int FP_W     = CMAG_W + FIFTH_W + 1;
   localparam int SUM_W    = OUT_W + 1 + OUT_FRAC_BITS;
   localparam int Y3_W     = P_W + 1 - SH;
   localparam int R10_W    = Y3_W - 3;
   localparam int X1200_W  = P_W + 12;
   localparam int Y4_W     = X1200_W - SH;

   localparam logic [R10_W-1:0]     R10        = R10_W'((64'd1 << Y3_W) / DEC_DIV);
   localparam logic [FP_W-1:0]      FIFTH_BIAS = FP_W'(1) << (23 - OUT_FRAC_BITS);
   localparam logic [FL_W-1:0]      FINE_BIAS  = FL_W'(FINE_ZERO >> 1);
   localparam logic [P_W:0]         DEC_BIAS   = (P_W + 1)'(DEC_DIV / 2) << SH;
   localparam logic [X1200_W-1:0]   FIF_BIAS   = X1200_W'(FIFTHS_DIV) << (SH - 1);
   localparam logic signed [SUM_W-1:0] OCT_CENTS = SUM_W'(CENTS_OCTAVE) << OUT_FRAC_BITS;

   // 2^(k/N) in Q30, k = 0..N, exp series in Q32
   function automatic logic [POW_TABLE_ENTRIES:0][POW_W-1:0] build_rom();
      logic [POW_TABLE_ENTRIES:0][POW_W-1:0] rom;
      logic [63:0] x;
      logic [63:0] sum;
      logic [63:0] term;
      for (int k = 0; k <= POW_TABLE_ENTRIES; k++) begin
         x    = (64'(k) * LN2_Q32 + 64'(POW_TABLE_ENTRIES / 2)) / 64'(POW_TABLE_ENTRIES);
         sum  = 64'd1 << 32;
         term = 64'd1 << 32;
         for (int n = 1; n <= 24; n++) begin
            if (term != 64'd0) begin
               term = ((term * x) >> 32) / 64'(n);
               sum  = sum + term;
            end
         end
         rom[k] = POW_W'((sum + 64'd2) >> 2);
      end
      return rom;
   endfunction

   localparam logic [POW_TABLE_ENTRIES:0][POW_W-1:0] POW_ROM = build_rom();

   typedef struct packed {
      logic [TYPE_W-1:0]       dtype;
      logic                    c_neg;
      logic                    f_neg;
      logic signed [SUM_W-1:0] oct_term;
      logic [C_W-1:0]          c_val;
      logic [FV_W-1:0]         f_lin;
   } side_type;

   // ---------------- flow control ----------------
   logic [NSTAGE:1] vld_ff;
   logic [NSTAGE:1] vld_in;
   logic [NSTAGE:1] adv;

   always_comb begin
      adv[NSTAGE] = !vld_ff[NSTAGE] || !rsp_stall;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[1] = adv[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[1];
   assign rsp_valid = vld_ff[NSTAGE];

   // ---------------- stage 1: decode, fine exponent ----------------
   logic [STEP_W-1:0] step;
   logic              s1_c_neg_in;
   logic [CMAG_W-1:0] s1_c_mag_in;
   logic              s1_f_neg_in;
   logic [MAG_W-1:0]  s1_m_in;
   logic [K_W-1:0]    k_sel;
   logic [E_W-1:0]    s1_e_in;

   logic [TYPE_W-1:0] s1_type_ff;
   logic [OCT_W-1:0]  s1_oct_ff;
   logic              s1_c_neg_ff;
   logic [CMAG_W-1:0] s1_c_mag_ff;
   logic              s1_f_neg_ff;
   logic [MAG_W-1:0]  s1_m_ff;
   logic [E_W-1:0]    s1_e_ff;

   always_comb begin
      step        = req_coarse_word[STEP_W-1:0];
      s1_c_neg_in = step > STEP_HALF;
      s1_c_mag_in = s1_c_neg_in ? (~step + 1'b1) : step;
      s1_f_neg_in = req_fine_word < FINE_ZERO;
      s1_m_in     = s1_f_neg_in ? (FINE_ZERO - req_fine_word) : (req_fine_word - FINE_ZERO);
      k_sel       = (req_detune_type == DT_FIFTHS) ? K_FIFTHS : K_DECIMAL;
      s1_e_in     = E_W'(s1_m_in) * E_W'(k_sel);
   end

   // ---------------- stage 2: table position, linear parts ----------------
   logic [POS_W-1:0]  pos;
   logic [FP_W-1:0]   fifth_sum;
   logic [FL_W-1:0]   ten_sum;
   logic [FL_W-1:0]   def_sum;
   side_type          side_in;
   logic [ROM_AW-1:0] s2_idx_in;

   logic [ROM_AW-1:0]    s2_idx_ff;
   logic [31:0]          s2_rem_ff;
   logic [EXP_INT_W-1:0] s2_ip_ff;
   side_type             side_ff [2:NSTAGE-1];

   always_comb begin
      pos       = POS_W'(s1_e_ff[31:0]) * POS_W'(POW_TABLE_ENTRIES);
      s2_idx_in = pos[32 +: ROM_AW];
      fifth_sum = FP_W'(s1_c_mag_ff) * FP_W'(FIFTH_Q24) + FIFTH_BIAS;
      ten_sum   = ((FL_W'(s1_m_ff) * FL_W'(FINE_MUL_TEN)) << OUT_FRAC_BITS) + FINE_BIAS;
      def_sum   = ((FL_W'(s1_m_ff) * FL_W'(FINE_MUL_DEF)) << OUT_FRAC_BITS) + FINE_BIAS;

      side_in.dtype    = s1_type_ff;
      side_in.c_neg    = s1_c_neg_ff;
      side_in.f_neg    = s1_f_neg_ff;
      side_in.oct_term = $signed(SUM_W'($signed(s1_oct_ff))) * OCT_CENTS;
      side_in.f_lin    = (s1_type_ff == DT_TEN_CENT) ? FV_W'(ten_sum >> FINE_SHIFT)
                                                     : FV_W'(def_sum >> FINE_SHIFT);
      unique case (s1_type_ff)
         DT_TEN_CENT: side_in.c_val = (C_W'(s1_c_mag_ff) * C_W'(SCALE_TEN)) << OUT_FRAC_BITS;
         DT_DECIMAL:  side_in.c_val = (C_W'(s1_c_mag_ff) * C_W'(SCALE_DEC)) << OUT_FRAC_BITS;
         DT_FIFTHS:   side_in.c_val = C_W'(fifth_sum >> (24 - OUT_FRAC_BITS));
         default:     side_in.c_val = (C_W'(s1_c_mag_ff) * C_W'(SCALE_DEF)) << OUT_FRAC_BITS;
      endcase
   end

   // ---------------- stage 3: table read ----------------
   logic [POW_W-1:0]     s3_lo_in;
   logic [POW_W-1:0]     s3_hi_in;
   logic [POW_W-1:0]     s3_lo_ff;
   logic [POW_W-1:0]     s3_hi_ff;
   logic [31:0]          s3_rem_ff;
   logic [EXP_INT_W-1:0] s3_ip_ff;

   always_comb begin
      s3_lo_in = POW_ROM[s2_idx_ff];
      s3_hi_in = POW_ROM[ROM_AW'(s2_idx_ff + 1'b1)];
   end

   // ---------------- stage 4: interpolation ----------------
   logic [POW_W-1:0]     diff;
   logic [63:0]          interp_prod;
   logic [31:0]          s4_interp_in;
   logic [31:0]          s4_interp_ff;
   logic [POW_W-1:0]     s4_lo_ff;
   logic [EXP_INT_W-1:0] s4_ip_ff;

   always_comb begin
      diff         = (s3_hi_ff >= s3_lo_ff) ? (s3_hi_ff - s3_lo_ff) : '0;
      interp_prod  = 64'(diff) * 64'(s3_rem_ff);
      s4_interp_in = interp_prod[63:32];
   end

   // ---------------- stage 5: 2^E, minus one ----------------
   logic [POW_W-1:0] pow_v;
   logic [P_W-1:0]   pow_p;
   logic [P_W-1:0]   s5_x_in;
   logic [P_W-1:0]   s5_x_ff;

   always_comb begin
      pow_v   = s4_lo_ff + s4_interp_ff;
      pow_p   = P_W'(pow_v) << s4_ip_ff;
      s5_x_in = pow_p - P_W'(Q30_ONE);
   end

   // ---------------- stage 6: per-type scaling with rounding bias ----------------
   logic [P_W:0]       dec_sum;
   logic [X1200_W-1:0] fif_sum;
   logic [Y3_W-1:0]    s6_y3_in;
   logic [Y4_W-1:0]    s6_y4_in;
   logic [Y3_W-1:0]    s6_y3_ff;
   logic [Y4_W-1:0]    s6_y4_ff;

   always_comb begin
      dec_sum  = (P_W + 1)'(s5_x_ff) + DEC_BIAS;
      fif_sum  = X1200_W'(s5_x_ff) * X1200_W'(FIFTHS_CENTS) + FIF_BIAS;
      s6_y3_in = Y3_W'(dec_sum >> SH);
      s6_y4_in = Y4_W'(fif_sum >> SH);
   end

   // ---------------- stage 7: quotient estimates ----------------
   // divide by 10: reciprocal, low by at most one
   // divide by 4095: 1/4096 * (1 + 2^-12 + 2^-24 + 2^-36), low by at most one
   logic [Y3_W+R10_W-1:0] dec_prod;
   logic [Y4_W:0]         fif_acc;
   logic [Y3_W-1:0]       s7_q3_in;
   logic [Y4_W-1:0]       s7_q4_in;
   logic [Y3_W-1:0]       s7_q3_ff;
   logic [Y4_W-1:0]       s7_q4_ff;
   logic [Y3_W-1:0]       s7_y3_ff;
   logic [Y4_W-1:0]       s7_y4_ff;

   always_comb begin
      dec_prod = (Y3_W + R10_W)'(s6_y3_ff) * (Y3_W + R10_W)'(R10);
      s7_q3_in = Y3_W'(dec_prod >> Y3_W);
      fif_acc  = (Y4_W + 1)'(s6_y4_ff) + (Y4_W + 1)'(s6_y4_ff >> FIFTHS_DIV_SH)
               + (Y4_W + 1)'(s6_y4_ff >> (2 * FIFTHS_DIV_SH))
               + (Y4_W + 1)'(s6_y4_ff >> (3 * FIFTHS_DIV_SH));
      s7_q4_in = Y4_W'(fif_acc >> FIFTHS_DIV_SH);
   end

   // ---------------- stage 8: quotient correction, fine select ----------------
   logic [Y3_W-1:0] dec_rem;
   logic [Y4_W-1:0] fif_rem;
   logic [Y3_W-1:0] dec_q;
   logic [Y4_W-1:0] fif_q;
   logic [FV_W-1:0] s8_f_in;
   logic [FV_W-1:0] s8_f_ff;

   always_comb begin
      dec_rem = s7_y3_ff - Y3_W'(s7_q3_ff * Y3_W'(DEC_DIV));
      fif_rem = s7_y4_ff - ((s7_q4_ff << FIFTHS_DIV_SH) - s7_q4_ff);
      dec_q   = (dec_rem >= Y3_W'(DEC_DIV)) ? (s7_q3_ff + 1'b1) : s7_q3_ff;
      fif_q   = (fif_rem >= Y4_W'(FIFTHS_DIV)) ? (s7_q4_ff + 1'b1) : s7_q4_ff;
      unique case (side_ff[7].dtype)
         DT_DECIMAL: s8_f_in = FV_W'(dec_q);
         DT_FIFTHS:  s8_f_in = FV_W'(fif_q);
         default:    s8_f_in = side_ff[7].f_lin;
      endcase
   end

   // ---------------- stage 9: signed sum, saturation ----------------
   logic signed [SUM_W-1:0] c_term;
   logic signed [SUM_W-1:0] f_term;
   logic signed [SUM_W-1:0] total;
   logic [SUM_W-OUT_W:0]    top_bits;
   logic [OUT_W-1:0]        out_in;
   logic [OUT_W-1:0]        out_ff;

   always_comb begin
      c_term   = side_ff[8].c_neg ? -$signed(SUM_W'(side_ff[8].c_val))
                                  : $signed(SUM_W'(side_ff[8].c_val));
      f_term   = side_ff[8].f_neg ? -$signed(SUM_W'(s8_f_ff))
                                  : $signed(SUM_W'(s8_f_ff));
      total    = side_ff[8].oct_term + c_term + f_term;
      top_bits = total[SUM_W-1:OUT_W-1];
      if ((&top_bits) || !(|top_bits)) begin
         out_in = total[OUT_W-1:0];
      end else begin
         out_in = {total[SUM_W-1], {(OUT_W-1){~total[SUM_W-1]}}};
      end
   end

   assign rsp_cents_offset = out_ff;

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_type_ff  <= req_detune_type;
         s1_oct_ff   <= req_coarse_word[COARSE_W-1:STEP_W];
         s1_c_neg_ff <= s1_c_neg_in;
         s1_c_mag_ff <= s1_c_mag_in;
         s1_f_neg_ff <= s1_f_neg_in;
         s1_m_ff     <= s1_m_in;
         s1_e_ff     <= s1_e_in;
      end
      if (adv[2]) begin
         s2_idx_ff  <= s2_idx_in;
         s2_rem_ff  <= pos[31:0];
         s2_ip_ff   <= s1_e_ff[32 +: EXP_INT_W];
         side_ff[2] <= side_in;
      end
      if (adv[3]) begin
         s3_lo_ff  <= s3_lo_in;
         s3_hi_ff  <= s3_hi_in;
         s3_rem_ff <= s2_rem_ff;
         s3_ip_ff  <= s2_ip_ff;
      end
      if (adv[4]) begin
         s4_interp_ff <= s4_interp_in;
         s4_lo_ff     <= s3_lo_ff;
         s4_ip_ff     <= s3_ip_ff;
      end
      if (adv[5]) begin
         s5_x_ff <= s5_x_in;
      end
      if (adv[6]) begin
         s6_y3_ff <= s6_y3_in;
         s6_y4_ff <= s6_y4_in;
      end
      if (adv[7]) begin
         s7_q3_ff <= s7_q3_in;
         s7_q4_ff <= s7_q4_in;
         s7_y3_ff <= s6_y3_ff;
         s7_y4_ff <= s6_y4_ff;
      end
      if (adv[8]) begin
         s8_f_ff <= s8_f_in;
      end
      for (int k = 3; k <= NSTAGE - 1; k++) begin
         if (adv[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
      if (adv[NSTAGE]) begin
         out_ff <= out_in;
      end
   end

   // ---------------- assertions ----------------
   `DTC_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, vld_ff[1], "accepted request did not enter stage 1")
   `DTC_ASSERT_NEXT(a_stage8_holds, clock, reset, vld_ff[8] && !adv[8], vld_ff[8], "blocked request left stage 8")
   `DTC_ASSERT_IMPLY(a_dec_est, clock, reset, vld_ff[7], dec_rem < Y3_W'(2 * DEC_DIV), "divide by 10 estimate off by more than one")
   `DTC_ASSERT_IMPLY(a_fif_est, clock, reset, vld_ff[7], fif_rem < Y4_W'(2 * FIFTHS_DIV), "divide by 4095 estimate off by more than one")

endmodule
